### src/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define SIRDIG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold on every rising edge outside reset.
`define SIRDIG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

### src/sirdig_pkg.sv
// Package with the types and constants of the integer-to-radix-digits block.
package sirdig_pkg;

  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic [4:0] MAX_RADIX  = 5'd16;
  localparam logic [4:0] MIN_RADIX  = 5'd2;
  localparam int         MAX_DIGITS = 32;
  localparam int         DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int         DIG_CNT_W  = DIG_IDX_W + 1;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_SYM_LOW  = 2'd0;
  localparam logic [1:0] REG_SYM_HIGH = 2'd1;
  localparam logic [1:0] REG_RADIX    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } sirdig_state_t;

endpackage

### src/signed_integer_to_radix_digits.sv
// Top level: writes a signed 32-bit integer as characters of a configured alphabet.
//
// Input stream in_*: one beat carries number_value in in_tdata. in_tready is high
// only while the sequencer is idle. Output stream out_*: one beat per character,
// out_tdata is the character byte and out_tlast marks the final character.
// Configuration is an APB port with three 64-bit registers at byte addresses
// 0 (symbols 0..7), 8 (symbols 8..15) and 16 (radix length).
//
// After an item is taken the alphabet is checked, one symbol per cycle against
// the later symbols inside the radix. An invalid alphabet drops the item with no
// output. Then one shared long-division unit, eight quotient bits per cycle,
// stores a digit after each pass over all four bytes of the magnitude, up to 32
// digits. Characters leave at one per cycle while out_tready is high: a '-' for a
// negative number, then the digits most significant first.
// The output register holds its beat while out_tready is low and the sequencer
// waits. A new item may be taken while the last character still waits.
// Reset clears the configuration registers, the sequencer and the output valid flag.
module signed_integer_to_radix_digits (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // [31:0] number_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [7:0] out_char
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW = sirdig_pkg::DIG_IDX_W;
  localparam int CW = sirdig_pkg::DIG_CNT_W;

  sirdig_pkg::sirdig_state_t state_r, state_nxt;

  logic [63:0]   sym_low_r;
  logic [63:0]   sym_high_r;
  logic [4:0]    radix_r;

  logic [31:0]   mag_r, mag_nxt;
  logic [3:0]    rem_r, rem_nxt;
  logic [1:0]    step_r, step_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [3:0]    chk_idx_r, chk_idx_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;
  logic          sign_pend_r, sign_pend_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_char_r, out_char_nxt;
  logic          out_last_r, out_last_nxt;

  logic [3:0]    store_r [sirdig_pkg::MAX_DIGITS];
  logic          store_we;
  logic [IW-1:0] store_wa;
  logic [3:0]    store_wd;

  logic [127:0]  sym_vec;
  logic [7:0]    chk_sym;
  logic          chk_bad;
  logic          chk_last;
  logic [4:0]    part;
  logic [3:0]    rem_w;
  logic [7:0]    qbits;
  logic [31:0]   quot;
  logic [3:0]    emit_digit;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_low_r  <= '0;
      sym_high_r <= '0;
      radix_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:3])
        sirdig_pkg::REG_SYM_LOW:  sym_low_r  <= cfg_pwdata;
        sirdig_pkg::REG_SYM_HIGH: sym_high_r <= cfg_pwdata;
        sirdig_pkg::REG_RADIX:    radix_r    <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:3])
      sirdig_pkg::REG_SYM_LOW:  cfg_prdata = sym_low_r;
      sirdig_pkg::REG_SYM_HIGH: cfg_prdata = sym_high_r;
      sirdig_pkg::REG_RADIX:    cfg_prdata = {59'd0, radix_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  assign sym_vec = {sym_high_r, sym_low_r};

  // Alphabet check for symbol chk_idx_r: forbidden characters, and any later
  // symbol inside the radix that repeats it.
  always_comb begin
    chk_sym = sym_vec[{chk_idx_r, 3'b000} +: 8];
    chk_bad = (chk_sym == sirdig_pkg::CH_PLUS) || (chk_sym == sirdig_pkg::CH_MINUS) ||
              (chk_sym == sirdig_pkg::CH_SPACE);
    for (int j = 0; j < 16; j++) begin
      if ((5'(j) > {1'b0, chk_idx_r}) && (5'(j) < radix_r) &&
          (sym_vec[j*8 +: 8] == chk_sym)) begin
        chk_bad = 1'b1;
      end
    end
  end

  assign chk_last = ({1'b0, chk_idx_r} + 5'd1) == radix_r;

  // Shared divider: eight restoring steps on the top byte of the magnitude.
  always_comb begin
    rem_w = rem_r;
    qbits = '0;
    part  = '0;
    for (int b = 0; b < 8; b++) begin
      part = {rem_w, mag_r[31-b]};
      if (part >= radix_r) begin
        part         = part - radix_r;
        qbits[7-b]   = 1'b1;
      end
      rem_w = part[3:0];
    end
  end

  assign quot       = {mag_r[23:0], qbits};
  assign emit_digit = store_r[ptr_r];

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[store_wa] <= store_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sirdig_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    rem_r       <= rem_nxt;
    step_r      <= step_nxt;
    cnt_r       <= cnt_nxt;
    chk_idx_r   <= chk_idx_nxt;
    ptr_r       <= ptr_nxt;
    sign_pend_r <= sign_pend_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    chk_idx_nxt   = chk_idx_r;
    ptr_nxt       = ptr_r;
    sign_pend_nxt = sign_pend_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    store_we      = 1'b0;
    store_wa      = cnt_r[IW-1:0];
    store_wd      = rem_w;
    in_tready     = 1'b0;

    unique case (state_r)
      sirdig_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          sign_pend_nxt = in_tdata[31];
          mag_nxt       = in_tdata[31] ? (~in_tdata + 32'd1) : in_tdata;
          chk_idx_nxt   = '0;
          // A radix out of range drops the item right here.
          if ((radix_r >= sirdig_pkg::MIN_RADIX) && (radix_r <= sirdig_pkg::MAX_RADIX)) begin
            state_nxt = sirdig_pkg::ST_CHECK;
          end
        end
      end
      sirdig_pkg::ST_CHECK: begin
        rem_nxt  = '0;
        step_nxt = '0;
        cnt_nxt  = '0;
        if (chk_bad) begin
          state_nxt = sirdig_pkg::ST_IDLE;
        end else if (chk_last) begin
          state_nxt = sirdig_pkg::ST_DIV;
        end else begin
          chk_idx_nxt = chk_idx_r + 4'd1;
        end
      end
      sirdig_pkg::ST_DIV: begin
        mag_nxt  = quot;
        rem_nxt  = rem_w;
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          store_we = 1'b1;
          rem_nxt  = '0;
          cnt_nxt  = cnt_r + CW'(1);
          ptr_nxt  = cnt_r[IW-1:0];
          if ((quot == '0) || (cnt_nxt == CW'(sirdig_pkg::MAX_DIGITS))) begin
            state_nxt = sirdig_pkg::ST_EMIT;
          end
        end
      end
      sirdig_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (sign_pend_r) begin
            sign_pend_nxt = 1'b0;
            out_char_nxt  = sirdig_pkg::CH_MINUS;
            out_last_nxt  = 1'b0;
          end else begin
            out_char_nxt = sym_vec[{emit_digit, 3'b000} +: 8];
            out_last_nxt = (ptr_r == '0);
            if (ptr_r == '0) begin
              state_nxt = sirdig_pkg::ST_IDLE;
            end else begin
              ptr_nxt = ptr_r - IW'(1);
            end
          end
        end
      end
      default: state_nxt = sirdig_pkg::ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

### src/sirdig_chk.sv
// Port-level checker for the integer-to-radix-digits block, with its bind.
`include "assert_macros.svh"

module sirdig_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  // A stalled character beat keeps its byte and its last flag.
  `SIRDIG_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output beat changed while stalled")

  // A plus or a space, which the alphabet check rejects, never leaves the block.
  `SIRDIG_ASSERT(a_no_plus_space, out_tvalid |-> (out_tdata != sirdig_pkg::CH_PLUS) && (out_tdata != sirdig_pkg::CH_SPACE), "forbidden symbol emitted")

  // A minus sign is always followed by at least one digit.
  `SIRDIG_ASSERT(a_minus_not_last, out_tvalid && (out_tdata == sirdig_pkg::CH_MINUS) |-> !out_tlast, "minus sign flagged as last character")

  // The block takes no new number while a non-final character waits.
  `SIRDIG_ASSERT(a_busy_no_accept, out_tvalid && !out_tlast |-> !in_tready, "input taken in the middle of a number")

endmodule

bind signed_integer_to_radix_digits sirdig_chk u_sirdig_chk (.*);

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the signed integer to radix digits block.
module tb;

  localparam int RANDOM_ITEMS  = 180;
  localparam int SETTLE_CYCLES = 200;

  // Symbols '0'..'7' and '8','9','A'..'F', one byte each, lowest symbol in the lowest byte.
  localparam logic [63:0] HEX_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [63:0] HEX_HIGH = 64'h4645_4443_4241_3938;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  typedef enum {ROW_WRITE, ROW_NUMBER, ROW_TYPED} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [63:0] wdata;
    logic [31:0] number;
    string       text;
  } stim_row_t;

  typedef enum {READY_ALWAYS, READY_ALTERNATE, READY_RANDOM, READY_SPARSE} ready_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  // Our own copy of the alphabet registers.
  logic [63:0] alpha_low = '0;
  logic [63:0] alpha_high = '0;
  logic [4:0]  radix_len = '0;

  char_beat_t  pending_chars[$];
  stim_row_t   stim_rows[$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  bit          sent_since_settle = 1'b0;

  ready_mode_t ready_mode = READY_ALWAYS;
  int          ready_mode_left = 0;
  logic [3:0]  ready_tick = '0;

  signed_integer_to_radix_digits u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: %s", $time, what);
  endtask

  function automatic logic [7:0] symbol_of(input logic [3:0] idx);
    logic [127:0] symbols;
    symbols = {alpha_high, alpha_low};
    return symbols[idx * 8 +: 8];
  endfunction

  function automatic bit alphabet_valid();
    logic [7:0] s;
    int i, j;
    if (radix_len < sirdig_pkg::MIN_RADIX || radix_len > sirdig_pkg::MAX_RADIX) return 1'b0;
    for (i = 0; i < radix_len; i++) begin
      s = symbol_of(4'(i));
      if (s == sirdig_pkg::CH_PLUS || s == sirdig_pkg::CH_MINUS ||
          s == sirdig_pkg::CH_SPACE) return 1'b0;
      for (j = i + 1; j < radix_len; j++) begin
        if (s == symbol_of(4'(j))) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Appends the characters that one number turns into; nothing for a bad alphabet.
  function automatic void predict_number(input logic [31:0] number);
    logic [3:0]  digits [sirdig_pkg::MAX_DIGITS];
    logic [31:0] mag;
    int n, k;
    if (!alphabet_valid()) return;
    // Unsigned negation keeps the most negative value exact.
    mag = number[31] ? 32'd0 - number : number;
    n = 0;
    do begin
      digits[n] = 4'(mag % radix_len);
      mag = mag / radix_len;
      n++;
    end while (mag != 0 && n < sirdig_pkg::MAX_DIGITS);
    if (number[31]) pending_chars.push_back('{sirdig_pkg::CH_MINUS, 1'b0});
    for (k = n - 1; k >= 0; k--) pending_chars.push_back('{symbol_of(digits[k]), k == 0});
  endfunction

  task automatic check_char(input logic [7:0] ch, input logic last);
    char_beat_t want;
    if (pending_chars.size() == 0) begin
      report_mismatch($sformatf("unexpected char %02h last %0b", ch, last));
      return;
    end
    want = pending_chars.pop_front();
    if (ch !== want.ch) report_mismatch($sformatf("char %02h, expected %02h", ch, want.ch));
    if (last !== want.last) begin
      report_mismatch($sformatf("last %0b, expected %0b (char %02h)", last, want.last, ch));
    end
  endtask

  // Output side: checks every beat and stalls on a pattern that changes now and then.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_char(out_tdata, out_tlast);
    ready_tick <= ready_tick + 1'b1;
    if (ready_mode_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      ready_mode_left <= $urandom_range(16, 120);
    end else begin
      ready_mode_left <= ready_mode_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS:    out_tready <= 1'b1;
      READY_ALTERNATE: out_tready <= ready_tick[0];
      READY_RANDOM:    out_tready <= 1'($urandom_range(0, 1));
      default:         out_tready <= (ready_tick == 4'd0);
    endcase
  end

  // Lets the block run dry: all expected characters seen, then time for a dropped item.
  task automatic settle_idle();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    if (sent_since_settle) repeat (SETTLE_CYCLES) @(posedge clk);
    sent_since_settle = 1'b0;
  endtask

  task automatic write_register(input logic [1:0] reg_idx, input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {reg_idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (reg_idx)
      sirdig_pkg::REG_SYM_LOW:  alpha_low = value;
      sirdig_pkg::REG_SYM_HIGH: alpha_high = value;
      sirdig_pkg::REG_RADIX:    radix_len = value[4:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Sends one number in bursts with gaps; expectations come from the text or the predictor.
  task automatic send_number(input logic [31:0] number, input bit typed, input string text);
    int gap, i;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 10);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= number;
    do @(posedge clk); while (!in_tready);
    sent_since_settle = 1'b1;
    if (typed) begin
      for (i = 0; i < text.len(); i++) pending_chars.push_back('{8'(text[i]), i == text.len() - 1});
    end else begin
      predict_number(number);
    end
  endtask

  task automatic draw_alphabet(input int want_len, output logic [63:0] lo,
                               output logic [63:0] hi, output logic [4:0] len);
    logic [7:0] syms [16];
    int n, i, j;
    bit clash;
    n = (want_len != 0) ? want_len : $urandom_range(2, 16);
    // Slots past the radix stay fully random, forbidden bytes and repeats included.
    for (i = 0; i < 16; i++) syms[i] = 8'($urandom);
    for (i = 0; i < n; i++) begin
      do begin
        syms[i] = 8'($urandom);
        clash = (syms[i] == sirdig_pkg::CH_PLUS) || (syms[i] == sirdig_pkg::CH_MINUS) ||
                (syms[i] == sirdig_pkg::CH_SPACE);
        for (j = 0; j < i; j++) if (syms[j] == syms[i]) clash = 1'b1;
      end while (clash);
    end
    len = 5'(n);
    if (want_len == 0 && $urandom_range(0, 6) == 0) begin
      case ($urandom_range(0, 3))
        0: len = 5'($urandom_range(0, 1));
        1: len = 5'($urandom_range(17, 31));
        2: begin
          j = $urandom_range(0, n - 1);
          case ($urandom_range(0, 2))
            0:       syms[j] = sirdig_pkg::CH_PLUS;
            1:       syms[j] = sirdig_pkg::CH_MINUS;
            default: syms[j] = sirdig_pkg::CH_SPACE;
          endcase
        end
        default: begin
          i = $urandom_range(1, n - 1);
          syms[i] = syms[$urandom_range(0, i - 1)];
        end
      endcase
    end
    for (i = 0; i < 8; i++) begin
      lo[8 * i +: 8] = syms[i];
      hi[8 * i +: 8] = syms[8 + i];
    end
  endtask

  function automatic logic [31:0] draw_number();
    logic [63:0] power;
    logic [31:0] v;
    int e;
    case ($urandom_range(0, 7))
      0, 1, 2: v = $urandom;
      3: v = $urandom_range(0, 300);
      4: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'd0;
          default: v = 32'd1;
        endcase
      end
      5: begin
        // Around a power of the radix, where the digit count steps.
        power = 64'd1;
        e = $urandom_range(1, 31);
        while (e > 0 && power * radix_len <= 64'h7FFF_FFFF) begin
          power = power * radix_len;
          e--;
        end
        v = power[31:0] - 32'd1 + 32'($urandom_range(0, 2));
      end
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
    return v;
  endfunction

  initial begin
    logic [63:0] lo, hi;
    logic [4:0]  len;
    int          valid_items, phase, n_items;
    bit          usable;
    stim_rows = '{
      // Out of reset the radix is zero, so nothing comes out.
      '{ROW_TYPED,  sirdig_pkg::REG_RADIX,    64'd0,    32'd7,          ""},
      '{ROW_TYPED,  sirdig_pkg::REG_RADIX,    64'd0,    32'h8000_0000,  ""},
      '{ROW_WRITE,  sirdig_pkg::REG_SYM_LOW,  HEX_LOW,  32'd0,          ""},
      '{ROW_WRITE,  sirdig_pkg::REG_SYM_HIGH, HEX_HIGH, 32'd0,          ""},
      '{ROW_WRITE,  sirdig_pkg::REG_RADIX,    64'd10,   32'd0,          ""},
      '{ROW_TYPED,  sirdig_pkg::REG_RADIX,    64'd0,    32'd0,          "0"},
      '{ROW_TYPED,  sirdig_pkg::REG_RADIX,    64'd0,    32'hFFFF_FFFF,  "-1"},
      '{ROW_TYPED,  sirdig_pkg::REG_RADIX,    64'd0,    32'h7FFF_FFFF,  "2147483647"},
      '{ROW_TYPED,  sirdig_pkg::REG_RADIX,    64'd0,    32'h8000_0000,  "-2147483648"},
      '{ROW_NUMBER, sirdig_pkg::REG_RADIX,    64'd0,    32'd1000,       ""},
      // Binary gives the longest output: sign and 32 digits.
      '{ROW_WRITE,  sirdig_pkg::REG_RADIX,    64'd2,    32'd0,          ""},
      '{ROW_NUMBER, sirdig_pkg::REG_RADIX,    64'd0,    32'h8000_0000,  ""},
      '{ROW_NUMBER, sirdig_pkg::REG_RADIX,    64'd0,    32'h7FFF_FFFF,  ""},
      '{ROW_NUMBER, sirdig_pkg::REG_RADIX,    64'd0,    32'd1,          ""},
      '{ROW_NUMBER, sirdig_pkg::REG_RADIX,    64'd0,    32'hFFFF_FFFE,  ""},
      '{ROW_WRITE,  sirdig_pkg::REG_RADIX,    64'd16,   32'd0,          ""},
      '{ROW_TYPED,  sirdig_pkg::REG_RADIX,    64'd0,    32'hFFFF_FFFF,  "-1"},
      '{ROW_TYPED,  sirdig_pkg::REG_RADIX,    64'd0,    32'h7FFF_FFFF,  "7FFFFFFF"},
      '{ROW_TYPED,  sirdig_pkg::REG_RADIX,    64'd0,    32'h8000_0000,  "-80000000"},
      '{ROW_NUMBER, sirdig_pkg::REG_RADIX,    64'd0,    32'h1234_5678,  ""},
      // Radix lengths out of range drop the item.
      '{ROW_WRITE,  sirdig_pkg::REG_RADIX,    64'd1,    32'd0,          ""},
      '{ROW_TYPED,  sirdig_pkg::REG_RADIX,    64'd0,    32'd5,          ""},
      '{ROW_WRITE,  sirdig_pkg::REG_RADIX,    64'd17,   32'd0,          ""},
      '{ROW_TYPED,  sirdig_pkg::REG_RADIX,    64'd0,    32'd5,          ""},
      '{ROW_WRITE,  sirdig_pkg::REG_RADIX,    64'd31,   32'd0,          ""},
      '{ROW_TYPED,  sirdig_pkg::REG_RADIX,    64'd0,    32'hFFFF_FFFB,  ""},
      // Ternary alphabets with a plus, a minus, a space, then a repeat in use.
      '{ROW_WRITE,  sirdig_pkg::REG_RADIX,    64'd3,    32'd0,          ""},
      '{ROW_WRITE,  sirdig_pkg::REG_SYM_LOW,  64'h3736_3534_3332_2B30, 32'd0, ""},
      '{ROW_TYPED,  sirdig_pkg::REG_RADIX,    64'd0,    32'd5,          ""},
      '{ROW_WRITE,  sirdig_pkg::REG_SYM_LOW,  64'h3736_3534_332D_3130, 32'd0, ""},
      '{ROW_TYPED,  sirdig_pkg::REG_RADIX,    64'd0,    32'd5,          ""},
      '{ROW_WRITE,  sirdig_pkg::REG_SYM_LOW,  64'h3736_3534_3332_3120, 32'd0, ""},
      '{ROW_TYPED,  sirdig_pkg::REG_RADIX,    64'd0,    32'd5,          ""},
      '{ROW_WRITE,  sirdig_pkg::REG_SYM_LOW,  64'h3736_3534_3330_3130, 32'd0, ""},
      '{ROW_TYPED,  sirdig_pkg::REG_RADIX,    64'd0,    32'd5,          ""},
      // A zero byte is an ordinary symbol, and a minus past the radix is ignored.
      '{ROW_WRITE,  sirdig_pkg::REG_SYM_LOW,  64'h3736_3534_2D32_3100, 32'd0, ""},
      '{ROW_NUMBER, sirdig_pkg::REG_RADIX,    64'd0,    32'd9,          ""},
      // Symbol fifteen repeats symbol zero across the two registers.
      '{ROW_WRITE,  sirdig_pkg::REG_RADIX,    64'd16,   32'd0,          ""},
      '{ROW_WRITE,  sirdig_pkg::REG_SYM_LOW,  64'h3736_3534_3332_3100, 32'd0, ""},
      '{ROW_WRITE,  sirdig_pkg::REG_SYM_HIGH, 64'h0045_4443_4241_3938, 32'd0, ""},
      '{ROW_TYPED,  sirdig_pkg::REG_RADIX,    64'd0,    32'd1,          ""}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < stim_rows.size(); r++) begin
      case (stim_rows[r].kind)
        ROW_WRITE: begin
          settle_idle();
          write_register(stim_rows[r].reg_idx, stim_rows[r].wdata);
        end
        ROW_TYPED: send_number(stim_rows[r].number, 1'b1, stim_rows[r].text);
        default:   send_number(stim_rows[r].number, 1'b0, "");
      endcase
    end

    // The first two phases pin the radix to its extremes.
    valid_items = 0;
    phase = 0;
    while (valid_items < RANDOM_ITEMS) begin
      draw_alphabet(phase == 0 ? 2 : (phase == 1 ? 16 : 0), lo, hi, len);
      settle_idle();
      write_register(sirdig_pkg::REG_SYM_LOW, lo);
      write_register(sirdig_pkg::REG_SYM_HIGH, hi);
      write_register(sirdig_pkg::REG_RADIX, {59'd0, len});
      usable = alphabet_valid();
      n_items = usable ? $urandom_range(8, 30) : 3;
      repeat (n_items) begin
        send_number(draw_number(), 1'b0, "");
        if (usable) valid_items++;
      end
      phase++;
    end

    settle_idle();
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/sirdig_pkg.sv
src/signed_integer_to_radix_digits.sv
src/sirdig_chk.sv
tb/tb.sv
